/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the RTL files that carry checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define TSHW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define TSHW_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* sv/tshw_pkg.sv */
// ---------------------------------------------------------------------------
// tshw_pkg
// Types and constants for the transport packet header and stuffing writer.
// ---------------------------------------------------------------------------
package tshw_pkg;

  localparam logic [7:0]  TS_SYNC_BYTE    = 8'h47;
  localparam logic [7:0]  TS_STUFF_BYTE   = 8'hFF;
  localparam logic [7:0]  TS_PAYLOAD_MAX  = 8'd184;
  localparam logic [1:0]  ADAPT_CTRL_PAYLOAD_ONLY = 2'd1;
  localparam logic [1:0]  ADAPT_CTRL_FIELD_AND_PAYLOAD = 2'd3;

  localparam int unsigned LEN_W   = 12;
  localparam int unsigned PID_W   = 13;
  localparam int unsigned CC_W    = 4;
  localparam int unsigned WIDX_W  = 6;
  localparam int unsigned VB_W    = 3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } tshw_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new descriptor, restart at word zero
    logic advance;  // step to the next output word
  } tshw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // the current word is the final one of the packet
  } tshw_sts_t;

endpackage

/* sv/tshw_ctrl.sv */
// ---------------------------------------------------------------------------
// tshw_ctrl
// Controller: sequences descriptor intake and output word transfers.
// ---------------------------------------------------------------------------
module tshw_ctrl
  import tshw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  tshw_sts_t sts_i,
  output tshw_cmd_t cmd_o
);

  tshw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        // The next descriptor may be taken in the cycle the last word leaves.
        in_ready_o  = out_ready_i && sts_i.last;
        if (out_ready_i) begin
          if (!sts_i.last) begin
            cmd_o.advance = 1'b1;
          end else if (in_valid_i) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/tshw_datapath.sv */
// ---------------------------------------------------------------------------
// tshw_datapath
// Datapath: holds the packet descriptor and builds each output word.
// ---------------------------------------------------------------------------
module tshw_datapath
  import tshw_pkg::*;
(
  input  logic             clk_i,
  input  tshw_cmd_t        cmd_i,
  output tshw_sts_t        sts_o,
  input  logic             payload_start_i,
  input  logic [LEN_W-1:0] payload_length_i,
  input  logic [PID_W-1:0] packet_id_i,
  input  logic [CC_W-1:0]  continuity_count_i,
  output logic [31:0]      packed_word_o,
  output logic [VB_W-1:0]  valid_bytes_o,
  output logic             last_word_o
);

  logic              ps_q;
  logic [PID_W-1:0]  pid_q;
  logic [CC_W-1:0]   cc_q;
  logic [7:0]        af_q;
  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [WIDX_W-1:0] last_idx_q, last_idx_d;

  logic [7:0]        clamped_len;
  logic [7:0]        af_d;
  logic [8:0]        round_sum;
  logic [1:0]        tail_bytes;
  logic [1:0]        adapt_ctrl;
  logic [7:0]        af_len_byte;
  logic [31:0]       raw_word;
  logic [31:0]       lane_mask;

  // Adaptation field length and last word index of the incoming descriptor, and the next word index.
  always_comb begin
    clamped_len = (payload_length_i > LEN_W'(TS_PAYLOAD_MAX)) ? TS_PAYLOAD_MAX
                                                              : payload_length_i[7:0];
    af_d        = TS_PAYLOAD_MAX - clamped_len;
    round_sum   = {1'b0, af_d} + 9'd7;
    last_idx_d  = round_sum[7:2] - WIDX_W'(1);
    widx_d      = cmd_i.load ? '0 : (cmd_i.advance ? widx_q + WIDX_W'(1) : widx_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ps_q       <= payload_start_i;
      pid_q      <= packet_id_i;
      cc_q       <= continuity_count_i;
      af_q       <= af_d;
      last_idx_q <= last_idx_d;
    end
    widx_q <= widx_d;
  end

  always_comb begin
    adapt_ctrl  = (af_q == 8'd0) ? ADAPT_CTRL_PAYLOAD_ONLY : ADAPT_CTRL_FIELD_AND_PAYLOAD;
    af_len_byte = (af_q == 8'd1) ? 8'h00 : af_q - 8'd1;
    if (widx_q == '0) begin
      raw_word = {TS_SYNC_BYTE, 1'b0, ps_q, 1'b0, pid_q[12:8], pid_q[7:0],
                  2'b00, adapt_ctrl, cc_q};
    end else if (widx_q == WIDX_W'(1)) begin
      raw_word = {af_len_byte, 8'h00, TS_STUFF_BYTE, TS_STUFF_BYTE};
    end else begin
      raw_word = {4{TS_STUFF_BYTE}};
    end

    last_word_o = (widx_q == last_idx_q);
    // Bytes in the final word: ((4 + F) mod 4), with zero meaning four.
    tail_bytes  = af_q[1:0] + 2'd3;
    valid_bytes_o = last_word_o ? ({1'b0, tail_bytes} + 3'd1) : 3'd4;

    for (int k = 0; k < 4; k++) begin
      lane_mask[31-8*k -: 8] = (VB_W'(k) < valid_bytes_o) ? 8'hFF : 8'h00;
    end
    packed_word_o = raw_word & lane_mask;
    sts_o.last    = last_word_o;
  end

endmodule

/* sv/ts_packet_header_stuffing_writer_core.sv */
// ---------------------------------------------------------------------------
// ts_packet_header_stuffing_writer_core
// Transport packet header and adaptation-field stuffing writer.
// ---------------------------------------------------------------------------
// Each descriptor transfer on the slave stream describes one 188-byte
// transport packet. The block answers with the packet's 4-byte header and,
// when the payload is shorter than 184 bytes, an adaptation field that pads
// the packet out, all as big-endian 32-bit words on the master stream (first
// byte in bits 31..24). A descriptor produces between 1 and 47 word
// transfers, one per clock cycle while the master side is ready; the word
// counter in the datapath sets that rate, and a packet has ceil((4 + F) / 4)
// words, where F = 184 - min(payload_length, 184). The
// next descriptor is accepted in the same cycle that the final word of the
// current packet is transferred, so packets follow each other without a gap.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ts_packet_header_stuffing_writer_core
  import tshw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Descriptor stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] payload_length, [24:12] packet_id, [28:25] continuity_count,
  // [31:29] zero.
  input  logic [31:0] s_axis_tdata,
  // [0] payload_start.
  input  logic        s_axis_tuser,
  // Packet word stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] packed_word.
  output logic [31:0] m_axis_tdata,
  // [2:0] valid_bytes.
  output logic [2:0]  m_axis_tuser,
  // Set on the final word of the packet's header and adaptation field.
  output logic        m_axis_tlast
);

  tshw_cmd_t cmd;
  tshw_sts_t sts;

  // The controller decides when a descriptor is taken and when the word
  // counter steps; the output word itself is a function of registered state.
  tshw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the descriptor, the adaptation field length and the
  // word index, and assembles header, length and stuffing bytes per word.
  tshw_datapath u_datapath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .payload_start_i    (s_axis_tuser),
    .payload_length_i   (s_axis_tdata[11:0]),
    .packet_id_i        (s_axis_tdata[24:12]),
    .continuity_count_i (s_axis_tdata[28:25]),
    .packed_word_o      (m_axis_tdata),
    .valid_bytes_o      (m_axis_tuser),
    .last_word_o        (m_axis_tlast)
  );

  // A taken descriptor always starts with the full header word.
  `TSHW_ASSERT(a_hdr_word_full, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid && m_axis_tuser == 3'd4))
  // While words are pending, a descriptor is taken only as the last one leaves.
  `TSHW_ASSERT(a_ready_on_last, clk_i, rst_ni,
               (s_axis_tready && m_axis_tvalid) |-> (m_axis_tready && m_axis_tlast))
  // After the last word leaves with no new descriptor, the output goes quiet.
  `TSHW_ASSERT(a_idle_after_last, clk_i, rst_ni,
               (m_axis_tvalid && m_axis_tready && m_axis_tlast && !s_axis_tvalid)
                 |=> !m_axis_tvalid)
  // Only the final word of a packet may be partially filled.
  `TSHW_NEVER(a_partial_not_last, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tlast && m_axis_tuser != 3'd4)

endmodule
